// ===== hw/rtl/dtr_pkg.sv =====
// package for the divider timer with reload: item types, codes and bit-pick helper
// depends on nothing; imported by divider_timer_with_reload_top
package dtr_pkg;

  localparam int unsigned DIVIDER_WIDTH = 16;

  // mode codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // register select codes
  localparam logic [1:0] REG_DIV     = 2'd0;
  localparam logic [1:0] REG_COUNTER = 2'd1;
  localparam logic [1:0] REG_RELOAD  = 2'd2;
  localparam logic [1:0] REG_CONTROL = 2'd3;

  localparam logic [7:0] CTRL_READ_ONES = 8'hF8;
  localparam logic [7:0] CTRL_MASK      = 8'h07;

  typedef logic [DIVIDER_WIDTH-1:0] div_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
  } out_t;

  // divider bit watched for each rate select: 9, 3, 5, 7
  function automatic logic pick_bit(input div_t div, input logic [1:0] sel);
    logic b;
    unique case (sel)
      2'd0: b = div[9];
      2'd1: b = div[3];
      2'd2: b = div[5];
      2'd3: b = div[7];
      default: b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/divider_timer_with_reload_top.sv =====
// divider timer with reload: divider, counter, reload and control registers
// plus a two-entry output buffer; depends on dtr_pkg
// the result is registered into the output buffer when the item is accepted
// throughput: one item per cycle; the two-entry output buffer keeps accepting
// while one result waits, and ready drops only when both entries are full
// reset (rst, synchronous): divider, counter, reload and control registers clear to zero, the buffer to empty
module divider_timer_with_reload_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  dtr_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output dtr_pkg::out_t out_data
);
  import dtr_pkg::*;

  div_t       divider, divider_next;
  logic [7:0] counter, counter_next;
  logic [7:0] reload_value, reload_value_next;
  logic [2:0] control_bits, control_bits_next;

  out_t       buf0, buf1;
  logic [1:0] count;
  out_t       res;

  logic push, pop;
  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = buf0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  div_t       div_inc;
  logic [15:0] div_wide;
  logic [7:0] cnt_inc;
  logic       bump;
  logic       old_lvl, new_lvl;
  logic [2:0] ctl_wr;

  assign div_inc  = divider + div_t'(1);
  assign div_wide = 16'(divider);
  assign cnt_inc  = counter + 8'd1;
  assign ctl_wr   = in_data.write_data[2:0];
  assign old_lvl  = control_bits[2] && pick_bit(divider, control_bits[1:0]);
  assign new_lvl  = ctl_wr[2] && pick_bit(divider, ctl_wr[1:0]);

  always_comb begin
    divider_next      = divider;
    counter_next      = counter;
    reload_value_next = reload_value;
    control_bits_next = control_bits;
    res               = '0;
    bump              = 1'b0;
    unique case (in_data.mode)
      MODE_TICK: begin
        divider_next = div_inc;
        bump = old_lvl && !pick_bit(div_inc, control_bits[1:0]);
      end
      MODE_READ: begin
        unique case (in_data.reg_select)
          REG_DIV:     res.read_data = div_wide[15:8];
          REG_COUNTER: res.read_data = counter;
          REG_RELOAD:  res.read_data = reload_value;
          REG_CONTROL: res.read_data = CTRL_READ_ONES | {5'd0, control_bits};
          default:     res.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (in_data.reg_select)
          REG_DIV: begin
            // clearing the divider drops the gated level if it was high
            divider_next = '0;
            bump = old_lvl;
          end
          REG_COUNTER: begin
            counter_next  = in_data.write_data;
            res.read_data = in_data.write_data;
          end
          REG_RELOAD: begin
            reload_value_next = in_data.write_data;
            res.read_data     = in_data.write_data;
          end
          REG_CONTROL: begin
            control_bits_next = ctl_wr;
            bump = old_lvl && !new_lvl;
            res.read_data = CTRL_READ_ONES | (in_data.write_data & CTRL_MASK);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (bump) begin
      if (cnt_inc == 8'd0) begin
        counter_next    = reload_value;
        res.irq_request = 1'b1;
      end else begin
        counter_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider      <= '0;
      counter      <= '0;
      reload_value <= '0;
      control_bits <= '0;
    end else if (push) begin
      divider      <= divider_next;
      counter      <= counter_next;
      reload_value <= reload_value_next;
      control_bits <= control_bits_next;
    end
  end

  // two-entry output buffer, buf0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    priority if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      buf0 <= res;
    end else if (pop && count == 2'd2) begin
      buf0 <= buf1;
    end
    if (push && count == 2'd1 && !pop) begin
      buf1 <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output buffer count out of range");

  assert property (@(posedge clk) disable iff (rst)
    push && in_data.mode == MODE_READ |-> !res.irq_request)
    else $error("interrupt raised by a read");

  assert property (@(posedge clk) disable iff (rst)
    pop && count == 2'd2 |=> out_valid && out_data == $past(buf1))
    else $error("buffer head not advanced");

  assert property (@(posedge clk) disable iff (rst)
    push && in_data.mode == MODE_READ && in_data.reg_select == REG_CONTROL
    |-> res.read_data[7:3] == 5'h1F)
    else $error("control read missing upper ones");

endmodule
